FILE: rtl/core/rpc_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// RPC frame deframer assertion macros
// Shared forms for the concurrent checks on the deframer ports.
// ----------------------------------------------------------------------------
`ifndef RPC_FRAME_DEFRAMER_ASSERT_SVH
`define RPC_FRAME_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPCD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rpcd_pkg.sv
// ----------------------------------------------------------------------------
// RPC frame deframer package
// Types, field codes and stream layout shared by the deframer files.
// ----------------------------------------------------------------------------
package rpcd_pkg;

    // Header geometry: only the first 28 bytes carry fields.
    localparam int HEADER_BYTES   = 32;
    localparam int HDR_IDX_W      = $clog2(HEADER_BYTES);
    localparam int HDR_USED_BYTES = 28;

    // Big-endian field offsets within the header.
    localparam int OFS_VERSION = 4;
    localparam int OFS_FLAGS   = 6;
    localparam int OFS_SEQ     = 8;
    localparam int OFS_META    = 16;
    localparam int OFS_PAYLOAD = 20;
    localparam int OFS_STATUS  = 24;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;
    localparam int CFG_DATA_W = 33;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 33'h1_FFFF_FFFE;

    // Byte kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_META    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_SIZE   = 2'd2;

    // Stream widths.
    localparam int TDATA_W = 216;
    localparam int TUSER_W = 5;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_META    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [31:0]           magic;
        logic [15:0]           version;
        logic [CFG_DATA_W-1:0] body_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  byte_kind;
        logic [31:0] section_offset;
        logic        header_valid;
        logic [15:0] msg_flags;
        logic [63:0] msg_sequence;
        logic [31:0] msg_status;
        logic [31:0] meta_length;
        logic [31:0] payload_length;
        logic        message_end;
        logic [1:0]  error_code;
    } result_t;

endpackage

FILE: rtl/core/rpcd_parser.sv
// ----------------------------------------------------------------------------
// RPC frame deframer parser
// Holds the framing state and classifies one byte per step.
// ----------------------------------------------------------------------------
module rpcd_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [7:0]      data_byte,
    input  rpcd_pkg::cfg_t  cfg,
    output rpcd_pkg::result_t res
);
    import rpcd_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]            hdr_store_reg [HDR_USED_BYTES];
    logic [31:0]           meta_count_reg, meta_count_next;
    logic [31:0]           payload_count_reg, payload_count_next;
    logic [31:0]           meta_total_reg, meta_total_next;
    logic [31:0]           payload_total_reg, payload_total_next;
    logic [15:0]           held_flags_reg, held_flags_next;
    logic [63:0]           held_seq_reg, held_seq_next;
    logic [31:0]           held_status_reg, held_status_next;

    logic [31:0] hdr_magic, hdr_mlen, hdr_plen;
    logic [15:0] hdr_version;
    logic [32:0] body_sum;
    logic [31:0] meta_inc, payload_inc;
    logic        hdr_last;

    // Header fields read at fixed places of the store.
    assign hdr_magic   = {hdr_store_reg[0], hdr_store_reg[1],
                          hdr_store_reg[2], hdr_store_reg[3]};
    assign hdr_version = {hdr_store_reg[OFS_VERSION], hdr_store_reg[OFS_VERSION+1]};
    assign hdr_mlen    = {hdr_store_reg[OFS_META],   hdr_store_reg[OFS_META+1],
                          hdr_store_reg[OFS_META+2], hdr_store_reg[OFS_META+3]};
    assign hdr_plen    = {hdr_store_reg[OFS_PAYLOAD],   hdr_store_reg[OFS_PAYLOAD+1],
                          hdr_store_reg[OFS_PAYLOAD+2], hdr_store_reg[OFS_PAYLOAD+3]};
    assign body_sum    = {1'b0, hdr_mlen} + {1'b0, hdr_plen};
    assign meta_inc    = meta_count_reg + 32'd1;
    assign payload_inc = payload_count_reg + 32'd1;
    assign hdr_last    = (hdr_idx_reg == HDR_IDX_W'(HEADER_BYTES - 1));

    // Next state and the result of the byte being processed.
    always_comb begin
        phase_next         = phase_reg;
        hdr_idx_next       = hdr_idx_reg;
        meta_count_next    = meta_count_reg;
        payload_count_next = payload_count_reg;
        meta_total_next    = meta_total_reg;
        payload_total_next = payload_total_reg;
        held_flags_next    = held_flags_reg;
        held_seq_next      = held_seq_reg;
        held_status_next   = held_status_reg;
        res                = '0;
        res.out_byte       = data_byte;

        case (phase_reg)
            PH_META: begin
                res.byte_kind      = KIND_META;
                res.section_offset = meta_count_reg;
                meta_count_next    = meta_inc;
                if (meta_inc == meta_total_reg) begin
                    if (payload_total_reg == 32'd0) begin
                        res.message_end = 1'b1;
                        phase_next      = PH_HEADER;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                res.byte_kind      = KIND_PAYLOAD;
                res.section_offset = payload_count_reg;
                payload_count_next = payload_inc;
                if (payload_inc == payload_total_reg) begin
                    res.message_end = 1'b1;
                    phase_next      = PH_HEADER;
                end
            end
            default: begin
                // Header collection; the unused phase code lands here too.
                phase_next         = PH_HEADER;
                res.byte_kind      = KIND_HEADER;
                res.section_offset = {{(32-HDR_IDX_W){1'b0}}, hdr_idx_reg};
                hdr_idx_next       = hdr_idx_reg + HDR_IDX_W'(1);
                if (hdr_last) begin
                    // The reserved tail byte completes the header: all fields are stored.
                    if (hdr_magic != cfg.magic || hdr_version != cfg.version) begin
                        res.error_code = ERR_HEADER;
                    end else if (body_sum > cfg.body_limit) begin
                        res.error_code = ERR_SIZE;
                    end else begin
                        res.header_valid   = 1'b1;
                        held_flags_next    = {hdr_store_reg[OFS_FLAGS],
                                              hdr_store_reg[OFS_FLAGS+1]};
                        held_seq_next      = {hdr_store_reg[OFS_SEQ],   hdr_store_reg[OFS_SEQ+1],
                                              hdr_store_reg[OFS_SEQ+2], hdr_store_reg[OFS_SEQ+3],
                                              hdr_store_reg[OFS_SEQ+4], hdr_store_reg[OFS_SEQ+5],
                                              hdr_store_reg[OFS_SEQ+6], hdr_store_reg[OFS_SEQ+7]};
                        held_status_next   = {hdr_store_reg[OFS_STATUS],
                                              hdr_store_reg[OFS_STATUS+1],
                                              hdr_store_reg[OFS_STATUS+2],
                                              hdr_store_reg[OFS_STATUS+3]};
                        meta_total_next    = hdr_mlen;
                        payload_total_next = hdr_plen;
                        meta_count_next    = 32'd0;
                        payload_count_next = 32'd0;
                        if (hdr_mlen == 32'd0 && hdr_plen == 32'd0) begin
                            res.message_end = 1'b1;
                        end else if (hdr_mlen != 32'd0) begin
                            phase_next = PH_META;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
        endcase

        // Held fields show the header in force after this byte.
        res.msg_flags      = held_flags_next;
        res.msg_sequence   = held_seq_next;
        res.msg_status     = held_status_next;
        res.meta_length    = meta_total_next;
        res.payload_length = payload_total_next;
    end

    // Framing state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            hdr_idx_reg       <= '0;
            meta_count_reg    <= '0;
            payload_count_reg <= '0;
            meta_total_reg    <= '0;
            payload_total_reg <= '0;
            held_flags_reg    <= '0;
            held_seq_reg      <= '0;
            held_status_reg   <= '0;
        end else if (step) begin
            phase_reg         <= phase_next;
            hdr_idx_reg       <= hdr_idx_next;
            meta_count_reg    <= meta_count_next;
            payload_count_reg <= payload_count_next;
            meta_total_reg    <= meta_total_next;
            payload_total_reg <= payload_total_next;
            held_flags_reg    <= held_flags_next;
            held_seq_reg      <= held_seq_next;
            held_status_reg   <= held_status_next;
        end
    end

    // Header byte store; the reserved tail bytes are not kept.
    always_ff @(posedge aclk) begin
        if (step && phase_reg != PH_META && phase_reg != PH_PAYLOAD
                && hdr_idx_reg < HDR_IDX_W'(HDR_USED_BYTES)) begin
            hdr_store_reg[hdr_idx_reg] <= data_byte;
        end
    end

endmodule

FILE: rtl/core/rpc_frame_deframer.sv
// ----------------------------------------------------------------------------
// RPC frame deframer
// Splits a byte stream into 32-byte headers and meta/payload body bytes.
// ----------------------------------------------------------------------------
// Each byte passes through the input register and then the result register,
// which drives the m_ side. Throughput: one byte per cycle while m_tready
// keeps up; the input register and the result register each hold one request,
// so while a result waits one more byte can still enter.
// Reset (aresetn low, synchronous) empties both registers, returns framing to
// the first header byte, clears held header fields and loads register defaults.
module rpc_frame_deframer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [rpcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpcd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Byte input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // data_byte
    // Result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_byte, section_offset, msg_flags, msg_sequence, msg_status,
    // meta_length, payload_length
    output logic [rpcd_pkg::TDATA_W-1:0]         m_tdata,
    // byte_kind, header_valid, error_code
    output logic [rpcd_pkg::TUSER_W-1:0]         m_tuser,
    output logic                                 m_tlast    // message_end
);
    import rpcd_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        m_valid_reg;
    result_t     m_res_reg;
    result_t     res;
    logic        advance;

    // A byte moves into the result register when that register is free or draining.
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic      <= '0;
            cfg_reg.version    <= '0;
            cfg_reg.body_limit <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAGIC:   cfg_reg.magic      <= cfg_data[31:0];
                CFG_VERSION: cfg_reg.version    <= cfg_data[15:0];
                CFG_LIMIT:   cfg_reg.body_limit <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    rpcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.payload_length, m_res_reg.meta_length,
                       m_res_reg.msg_status, m_res_reg.msg_sequence,
                       m_res_reg.msg_flags, m_res_reg.section_offset,
                       m_res_reg.out_byte};
    assign m_tuser  = {m_res_reg.error_code, m_res_reg.header_valid, m_res_reg.byte_kind};
    assign m_tlast  = m_res_reg.message_end;

endmodule

FILE: rtl/core/rpcd_checker.sv
// ----------------------------------------------------------------------------
// RPC frame deframer port checker
// Watches the deframer ports for framing and result hold rules.
// ----------------------------------------------------------------------------
`include "rpc_frame_deframer_assert.svh"

module rpcd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rpcd_pkg::TDATA_W-1:0]    m_tdata,
    input logic [rpcd_pkg::TUSER_W-1:0]    m_tuser,
    input logic                            m_tlast
);
    import rpcd_pkg::*;

    logic [1:0] kind;
    logic       hvalid;
    logic [1:0] err;
    logic [31:0] offset;

    assign kind   = m_tuser[1:0];
    assign hvalid = m_tuser[2];
    assign err    = m_tuser[4:3];
    assign offset = m_tdata[39:8];

    // A stalled result keeps its contents.
    `RPCD_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // An error appears only on the last header byte and ends nothing.
    `RPCD_ASSERT_SAME(a_err_place, aclk, aresetn, m_tvalid && err != ERR_NONE, kind == KIND_HEADER && offset == 32'(HEADER_BYTES - 1) && !hvalid && !m_tlast, "error outside last header byte")

    // An accepted header is flagged on its last byte only.
    `RPCD_ASSERT_SAME(a_hdr_place, aclk, aresetn, m_tvalid && hvalid, kind == KIND_HEADER && offset == 32'(HEADER_BYTES - 1) && err == ERR_NONE, "header accept misplaced")

    // A message can end on a header byte only with an empty, accepted header.
    `RPCD_ASSERT_SAME(a_empty_end, aclk, aresetn, m_tvalid && m_tlast && kind == KIND_HEADER, hvalid && m_tdata[215:152] == 64'd0, "header byte ended a non-empty message")

endmodule

bind rpc_frame_deframer rpcd_checker u_rpcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: test/tb_rpc_frame_deframer.sv
// ----------------------------------------------------------------------------
// RPC frame deframer testbench
// Sends byte streams made of 32-byte headers and meta/payload bodies, together
// with rejected headers, cut-off headers and line noise. A byte-level
// predictor computes the expected tagging of every byte, and each result on
// the m_ side is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_rpc_frame_deframer;
    import rpcd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [32:0] LIMIT_MAX = 33'h1_FFFF_FFFE;

    // ------------------------------------------------------------------------
    // Predictor and store of expected byte results.
    // ------------------------------------------------------------------------
    class deframer_scoreboard;
        result_t     pending[$];
        int unsigned errors;
        int unsigned bytes_seen;
        int unsigned results_seen;
        int unsigned headers_ok;
        int unsigned headers_bad;
        int unsigned headers_big;
        int unsigned messages_done;

        // Register copies.
        logic [31:0] magic_reg;
        logic [15:0] version_reg;
        logic [32:0] limit_reg;

        // Framing state.
        phase_t      framing;
        logic [5:0]  hdr_count;
        logic [7:0]  hdr_bytes[HEADER_BYTES];
        logic [31:0] meta_done;
        logic [31:0] payload_done;
        logic [31:0] meta_total;
        logic [31:0] payload_total;
        logic [15:0] kept_flags;
        logic [63:0] kept_sequence;
        logic [31:0] kept_status;

        function new();
            magic_reg     = '0;
            version_reg   = '0;
            limit_reg     = LIMIT_RESET;
            framing       = PH_HEADER;
            hdr_count     = '0;
            meta_done     = '0;
            payload_done  = '0;
            meta_total    = '0;
            payload_total = '0;
            kept_flags    = '0;
            kept_sequence = '0;
            kept_status   = '0;
            foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
        endfunction

        function void set_regs(logic [31:0] magic, logic [15:0] version,
                               logic [32:0] limit);
            magic_reg   = magic;
            version_reg = version;
            limit_reg   = limit;
        endfunction

        // True when the next byte is the first byte of a header.
        function bit at_frame_start();
            return framing == PH_HEADER && hdr_count == 0;
        endfunction

        // Big-endian field from the collected header.
        function logic [63:0] hdr_field(int pos, int len);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < len; i++) v = {v[55:0], hdr_bytes[pos + i]};
            return v;
        endfunction

        // Works out the result of one accepted byte and queues it.
        function void note_byte(logic [7:0] b);
            result_t     r;
            logic [4:0]  idx;
            logic [31:0] mlen;
            logic [31:0] plen;
            r = '0;
            r.out_byte = b;
            bytes_seen++;
            case (framing)
                PH_META: begin
                    r.byte_kind      = KIND_META;
                    r.section_offset = meta_done;
                    meta_done++;
                    if (meta_done == meta_total) begin
                        if (payload_total == 0) begin
                            r.message_end = 1'b1;
                            framing = PH_HEADER;
                        end else begin
                            framing = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r.byte_kind      = KIND_PAYLOAD;
                    r.section_offset = payload_done;
                    payload_done++;
                    if (payload_done == payload_total) begin
                        r.message_end = 1'b1;
                        framing = PH_HEADER;
                    end
                end
                default: begin
                    idx = hdr_count[4:0];
                    framing = PH_HEADER;
                    r.byte_kind = KIND_HEADER;
                    r.section_offset = 32'(idx);
                    hdr_bytes[idx] = b;
                    hdr_count = 6'(idx) + 6'd1;
                    if (hdr_count >= HEADER_BYTES) begin
                        hdr_count = '0;
                        mlen = 32'(hdr_field(OFS_META, 4));
                        plen = 32'(hdr_field(OFS_PAYLOAD, 4));
                        // Magic and version are checked ahead of the size.
                        if (hdr_field(0, 4) != magic_reg ||
                            hdr_field(OFS_VERSION, 2) != version_reg) begin
                            r.error_code = ERR_HEADER;
                            headers_bad++;
                        end else if ({1'b0, mlen} + {1'b0, plen} > limit_reg) begin
                            r.error_code = ERR_SIZE;
                            headers_big++;
                        end else begin
                            r.header_valid = 1'b1;
                            headers_ok++;
                            kept_flags    = 16'(hdr_field(OFS_FLAGS, 2));
                            kept_sequence = hdr_field(OFS_SEQ, 8);
                            kept_status   = 32'(hdr_field(OFS_STATUS, 4));
                            meta_total    = mlen;
                            payload_total = plen;
                            meta_done     = '0;
                            payload_done  = '0;
                            if (mlen == 0 && plen == 0) r.message_end = 1'b1;
                            else if (mlen != 0) framing = PH_META;
                            else framing = PH_PAYLOAD;
                        end
                    end
                end
            endcase
            if (r.message_end) messages_done++;
            r.msg_flags      = kept_flags;
            r.msg_sequence   = kept_sequence;
            r.msg_status     = kept_status;
            r.meta_length    = meta_total;
            r.payload_length = payload_total;
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Checks one result against the oldest expectation.
        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending.size() == 0) begin
                $error("result with no byte waiting: out_byte %0h", got.out_byte);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("byte_kind", want.byte_kind, got.byte_kind);
            compare_field("section_offset", want.section_offset, got.section_offset);
            compare_field("header_valid", want.header_valid, got.header_valid);
            compare_field("msg_flags", want.msg_flags, got.msg_flags);
            compare_field("msg_sequence", want.msg_sequence, got.msg_sequence);
            compare_field("msg_status", want.msg_status, got.msg_status);
            compare_field("meta_length", want.meta_length, got.meta_length);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("message_end", want.message_end, got.message_end);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance.
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAGIC;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // data_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // out_byte, section_offset, msg_flags, msg_sequence, msg_status,
    // meta_length, payload_length
    logic [TDATA_W-1:0]    m_tdata;
    // byte_kind, header_valid, error_code
    logic [TUSER_W-1:0]    m_tuser;
    logic                  m_tlast;          // message_end

    deframer_scoreboard sb = new();

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    rpc_frame_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (rx_idle_en) begin
            m_tready <= ($urandom_range(0, 99) >= 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.out_byte       = m_tdata[7:0];
            got.section_offset = m_tdata[39:8];
            got.msg_flags      = m_tdata[55:40];
            got.msg_sequence   = m_tdata[119:56];
            got.msg_status     = m_tdata[151:120];
            got.meta_length    = m_tdata[183:152];
            got.payload_length = m_tdata[215:184];
            got.byte_kind      = m_tuser[1:0];
            got.header_valid   = m_tuser[2];
            got.error_code     = m_tuser[4:3];
            got.message_end    = m_tlast;
            sb.check_result(got);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------------
    function automatic logic [255:0] pack_header(logic [31:0] magic, logic [15:0] version,
                                                 logic [15:0] flags, logic [63:0] seq,
                                                 logic [31:0] mlen, logic [31:0] plen,
                                                 logic [31:0] status, logic [31:0] rsv);
        return {magic, version, flags, seq, mlen, plen, status, rsv};
    endfunction

    // Offers one byte, with random gaps, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while (tx_idle_en && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b);
    endtask

    // Sends the first nbytes of a header, most significant byte first.
    task automatic send_header(input logic [255:0] hv, input int nbytes);
        for (int i = 0; i < nbytes; i++) send_byte(hv[255 - 8 * i -: 8]);
    endtask

    // Random bytes until the next byte would start a header; after an
    // accepted header this is exactly the body.
    task automatic sync_to_frame();
        while (!sb.at_frame_start()) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_message(input logic [255:0] hv);
        send_header(hv, HEADER_BYTES);
        sync_to_frame();
    endtask

    // Stops offering and waits until every expected result has come.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers while the block is idle.
    task automatic configure(input logic [31:0] magic, input logic [15:0] version,
                             input logic [32:0] limit);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAGIC;
        cfg_data  <= {1'b0, magic};
        @(posedge aclk);
        cfg_index <= CFG_VERSION;
        cfg_data  <= {17'b0, version};
        @(posedge aclk);
        cfg_index <= CFG_LIMIT;
        cfg_data  <= limit;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_regs(magic, version, limit);
    endtask

    // One random message: mostly well formed, the rest rejected headers,
    // cut-off headers or noise.
    task automatic random_msg();
        int          pick;
        logic [31:0] mg;
        logic [15:0] vr;
        logic [31:0] ml;
        logic [31:0] pl;
        logic [32:0] sum;
        logic [255:0] hv;
        pick = $urandom_range(0, 99);
        mg = sb.magic_reg;
        vr = sb.version_reg;
        ml = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
        pl = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
        if (pick >= 75 && pick < 90) begin
            // Full-range lengths: only allowed through when the limit rejects them.
            ml  = $urandom();
            pl  = $urandom();
            sum = {1'b0, ml} + {1'b0, pl};
            if (pick >= 83 || sum <= sb.limit_reg) begin
                if ($urandom_range(0, 1)) mg = mg ^ (32'h1 << $urandom_range(0, 31));
                else vr = vr ^ (16'h1 << $urandom_range(0, 15));
            end
        end
        hv = pack_header(mg, vr, 16'($urandom()), {$urandom(), $urandom()}, ml, pl,
                         $urandom(), $urandom());
        if (pick < 90) begin
            send_message(hv);
        end else if (pick < 95) begin
            send_header(hv, $urandom_range(1, HEADER_BYTES - 1));
            sync_to_frame();
        end else begin
            repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)));
            sync_to_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned start;
        bit          paused;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: register defaults (magic 0, version 0, largest limit).
        // Empty body with all-ones fields ends the message on the header.
        send_message(pack_header('0, '0, '1, '1, 32'd0, 32'd0, '1, '1));
        send_message(pack_header('0, '0, 16'h1234, 64'h0102_0304_0506_0708,
                                 32'd3, 32'd0, 32'hCAFE_0001, '0));
        // Empty meta section: body starts with payload.
        send_message(pack_header('0, '0, 16'h00F0, 64'd7, 32'd0, 32'd4, 32'd9, '0));
        send_message(pack_header('0, '0, 16'h8001, 64'd8, 32'd2, 32'd3, 32'd10, '0));
        // Bad magic and bad version leave the held fields alone.
        send_message(pack_header(32'h1, '0, '1, '1, 32'd1, 32'd1, '1, '0));
        send_message(pack_header('0, 16'h8000, '1, '1, 32'd1, 32'd1, '1, '0));

        // Directed: small limit.
        configure('0, '0, 33'd4);
        send_message(pack_header('0, '0, 16'h5, 64'd11, 32'd3, 32'd2, 32'd1, '0));
        // Both lengths at their maximum: the sum needs the 33rd bit.
        send_message(pack_header('0, '0, 16'h6, 64'd12, '1, '1, 32'd2, '0));
        // Both checks fail: the header error wins.
        send_message(pack_header(32'h8000_0000, '0, 16'h7, 64'd13, 32'd9, 32'd9, 32'd3, '0));
        // Exactly at the limit.
        send_message(pack_header('0, '0, 16'h8, 64'd14, 32'd2, 32'd2, 32'd4, '0));

        // Directed: all-ones magic and version, zero limit.
        configure('1, '1, 33'd0);
        send_message(pack_header('1, '1, 16'h9, 64'd15, 32'd0, 32'd0, 32'd5, '1));
        send_message(pack_header('1, '1, 16'hA, 64'd16, 32'd1, 32'd0, 32'd6, '0));
        send_message(pack_header('1, 16'h7FFF, 16'hB, 64'd17, 32'd0, 32'd0, 32'd7, '0));

        // Random phases under different register settings.
        for (int ph = 0; ph < 4; ph++) begin
            paused = 1'b0;
            case (ph)
                0: configure('1, '1, 33'($urandom_range(0, 12)));
                1: configure($urandom(), 16'($urandom()), LIMIT_MAX);
                2: configure($urandom(), 16'($urandom()),
                             {1'($urandom_range(0, 1)), $urandom()});
                default: configure('0, '0, 33'd8);
            endcase
            // The second phase runs without any idling on either side.
            tx_idle_en = (ph != 1);
            rx_idle_en = (ph != 1);
            // The third phase opens with a long receiver hold-off.
            if (ph == 2) hold_requests++;
            start = sb.bytes_seen;
            while (sb.bytes_seen - start < 240) begin
                random_msg();
                if (ph == 3 && !paused && sb.bytes_seen - start > 120) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        // Drain and let the pipeline settle.
        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("covered %0d bytes, %0d results: %0d headers taken, %0d complete messages",
                 sb.bytes_seen, sb.results_seen, sb.headers_ok, sb.messages_done);
        $display("rejected %0d headers for magic or version and %0d for body size",
                 sb.headers_bad, sb.headers_big);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rpcd_pkg.sv
rtl/core/rpcd_parser.sv
rtl/core/rpc_frame_deframer.sv
rtl/core/rpcd_checker.sv
test/tb_rpc_frame_deframer.sv
